### rtl/core/group_varint_word_decoder_unit_macros.svh
// Assertion macros shared by the group varint word decoder RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef GROUP_VARINT_WORD_DECODER_UNIT_MACROS_SVH
`define GROUP_VARINT_WORD_DECODER_UNIT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define GVWD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("group varint decoder check failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define GVWD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("group varint decoder check failed");

`endif

### rtl/core/gvwd_pkg.sv
// Types, constants and helper functions of the group varint word decoder.
// Used by gvwd_decode and group_varint_word_decoder_unit; depends on nothing.
package gvwd_pkg;

    localparam int POSITION_BITS = 24;
    localparam int CFG_DATA_BITS = 32;
    localparam int CFG_ADDR_BITS = 3;
    localparam int COUNT_BITS    = 3;

    // Register indexes on the configuration port.
    localparam logic REG_STREAM_LENGTH = 1'b0;

    // Parse phase, one-hot.
    typedef enum logic [3:0] {
        PHASE_HEADER  = 4'b0001,
        PHASE_CONTROL = 4'b0010,
        PHASE_DATA    = 4'b0100,
        PHASE_TAIL    = 4'b1000
    } phase_t;

    // Decoder state carried from byte to byte.
    typedef struct packed {
        logic [POSITION_BITS-1:0] byte_position;
        logic [7:0]               tail_count;
        logic [7:0]               control_byte;
        logic [1:0]               word_in_group;
        logic [2:0]               bytes_left_in_word;
        phase_t                   parse_phase;
    } dec_state_t;

    // Results caused by one input byte: the first byte is the stored or raw
    // byte (0 for a control byte that ends the stream); others are zero fill.
    typedef struct packed {
        logic [7:0]            first_byte;
        logic [COUNT_BITS-1:0] count;
        logic                  format_error;
        logic                  stream_last;
    } bundle_t;

    // Number of stored bytes (1 to 4) of a word, most significant pair first.
    function automatic logic [2:0] stored_bytes(input logic [7:0] ctrl,
                                                input logic [1:0] word);
        logic [1:0] code;
        unique case (word)
            2'd0: code = ctrl[7:6];
            2'd1: code = ctrl[5:4];
            2'd2: code = ctrl[3:2];
            default: code = ctrl[1:0];
        endcase
        return {1'b0, code} + 3'd1;
    endfunction

endpackage

### rtl/core/gvwd_decode.sv
// Single-byte decode step of the group varint word decoder.
// Depends on gvwd_pkg for the state and result bundle types.
module gvwd_decode
(
    input  gvwd_pkg::dec_state_t                 cur_state,
    input  logic [7:0]                           in_byte,
    input  logic [gvwd_pkg::POSITION_BITS-1:0]   stream_length,
    output gvwd_pkg::dec_state_t                 next_state,
    output gvwd_pkg::bundle_t                    bundle
);

    localparam int PB = gvwd_pkg::POSITION_BITS;

    logic [PB-1:0] len;
    logic [PB:0]   tail_plus_two;
    logic [PB-1:0] body_end;
    logic          is_last;
    logic [2:0]    left_dec;
    logic [2:0]    fill;

    // Effective length, last-byte test and start of the raw tail.
    always_comb
    begin
        len           = (stream_length < PB'(2)) ? PB'(2) : stream_length;
        is_last       = (cur_state.byte_position >= (len - PB'(1)));
        tail_plus_two = {{(PB+1-8){1'b0}}, cur_state.tail_count} + (PB+1)'(2);
        body_end      = (tail_plus_two > {1'b0, len}) ? PB'(2) :
                        (len - {{(PB-8){1'b0}}, cur_state.tail_count});
    end

    // Phase update and the results this byte causes.
    always_comb
    begin
        next_state          = cur_state;
        bundle.first_byte   = in_byte;
        bundle.count        = '0;
        bundle.format_error = 1'b0;
        bundle.stream_last  = is_last;
        left_dec            = (cur_state.bytes_left_in_word != 3'd0) ?
                              (cur_state.bytes_left_in_word - 3'd1) : 3'd0;
        fill                = 3'd4 - gvwd_pkg::stored_bytes(cur_state.control_byte,
                                                            cur_state.word_in_group);

        if (cur_state.byte_position == PB'(0))
        begin
            next_state.parse_phase = gvwd_pkg::PHASE_HEADER;
        end
        else if (cur_state.byte_position == PB'(1))
        begin
            next_state.tail_count  = in_byte;
            next_state.parse_phase = gvwd_pkg::PHASE_CONTROL;
        end
        else if (cur_state.byte_position >= body_end)
        begin
            // Raw tail byte; an unfinished group is abandoned without fill.
            bundle.format_error    = (cur_state.parse_phase == gvwd_pkg::PHASE_DATA);
            next_state.parse_phase = gvwd_pkg::PHASE_TAIL;
            bundle.count           = 3'd1;
        end
        else if (cur_state.parse_phase != gvwd_pkg::PHASE_DATA)
        begin
            // Control byte opens a group of four words.
            next_state.control_byte       = in_byte;
            next_state.word_in_group      = 2'd0;
            next_state.bytes_left_in_word = gvwd_pkg::stored_bytes(in_byte, 2'd0);
            next_state.parse_phase        = gvwd_pkg::PHASE_DATA;
            if (is_last)
            begin
                bundle.format_error = 1'b1;
                bundle.count        = 3'd1;
                bundle.first_byte   = 8'd0;
            end
        end
        else
        begin
            // Stored data byte, followed by zero fill when the word completes.
            bundle.count                  = 3'd1;
            next_state.bytes_left_in_word = left_dec;
            if (left_dec == 3'd0)
            begin
                bundle.count = 3'd1 + fill;
                if (cur_state.word_in_group == 2'd3)
                begin
                    next_state.word_in_group = 2'd0;
                    next_state.parse_phase   = gvwd_pkg::PHASE_CONTROL;
                end
                else
                begin
                    next_state.word_in_group      = cur_state.word_in_group + 2'd1;
                    next_state.bytes_left_in_word = gvwd_pkg::stored_bytes(
                        cur_state.control_byte, cur_state.word_in_group + 2'd1);
                end
            end
            if (is_last && (next_state.parse_phase == gvwd_pkg::PHASE_DATA))
            begin
                bundle.format_error = 1'b1;
            end
        end

        // The end of a stream rearms the parser for the next one.
        if (is_last)
        begin
            next_state.byte_position      = '0;
            next_state.parse_phase        = gvwd_pkg::PHASE_HEADER;
            next_state.word_in_group      = 2'd0;
            next_state.bytes_left_in_word = 3'd0;
        end
        else
        begin
            next_state.byte_position = cur_state.byte_position + PB'(1);
        end
    end

endmodule

### rtl/core/group_varint_word_decoder_unit.sv
// Group varint word decoder: stream-in of compressed bytes, stream-out of bytes.
// Depends on gvwd_pkg, gvwd_decode and group_varint_word_decoder_unit_macros.svh.
//
// Usage:
//   Write stream_length (total compressed bytes, header included) over the APB
//   port at address 0 while the block is idle; pready is always high.
//   Feed the compressed stream one word per cycle on the s_axis channel. The
//   marker and tail-count header words produce nothing, nor does a control word
//   unless it ends the stream; each data or tail word gives one to four output
//   words on m_axis: the stored or raw byte, then any zero fill of a completed
//   word. m_axis_tlast marks the final output word of an input word, tuser bit 0
//   marks the end of the stream, tuser bit 1 a format error.
//   Latency: the first output word of an input word appears the cycle after
//   it is accepted. The decode step is one combinational pass into a result
//   bundle register, so one input word is taken every cycle as long as each
//   produces at most one output word and the receiver is ready; a word with
//   fill bytes holds the output channel until its last fill byte is taken, and
//   that single bundle register takes the next input word in that same cycle.
//   Reset sets stream_length to 2 and restarts at a stream header. When the
//   receiver stalls, the pending bundle holds and s_axis_tready drops only
//   once the bundle can not be drained in the current cycle.
`include "group_varint_word_decoder_unit_macros.svh"

module group_varint_word_decoder_unit
(
    input  logic                                clk,
    input  logic                                rst_n,
    // Configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [gvwd_pkg::CFG_ADDR_BITS-1:0]  paddr,
    input  logic [gvwd_pkg::CFG_DATA_BITS-1:0]  pwdata,
    output logic [gvwd_pkg::CFG_DATA_BITS-1:0]  prdata,
    output logic                                pready,
    // Compressed input stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [7:0]                          s_axis_tdata,   // [7:0] in_byte
    // Decompressed output stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [7:0]                          m_axis_tdata,   // [7:0] out_byte
    output logic                                m_axis_tlast,   // run_last
    output logic [1:0]                          m_axis_tuser    // [0] stream_done,
                                                                // [1] format_error
);

    localparam int PB = gvwd_pkg::POSITION_BITS;
    localparam int CB = gvwd_pkg::COUNT_BITS;

    logic [PB-1:0]        stream_length_reg;
    gvwd_pkg::dec_state_t state_reg;
    gvwd_pkg::dec_state_t state_next;
    gvwd_pkg::dec_state_t dec_next;
    gvwd_pkg::bundle_t    dec_bundle;
    gvwd_pkg::bundle_t    bundle_reg;
    logic                 bundle_valid_reg;
    logic [1:0]           index_reg;
    logic                 in_accept;
    logic                 out_accept;
    logic                 elem_last;
    logic                 drain;
    logic                 cfg_write;

    // Configuration register: writes decode on the register index bit only.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready &&
                       (paddr[2] == gvwd_pkg::REG_STREAM_LENGTH);
    assign prdata    = (paddr[2] == gvwd_pkg::REG_STREAM_LENGTH) ?
                       {{(gvwd_pkg::CFG_DATA_BITS-PB){1'b0}}, stream_length_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stream_length_reg <= PB'(2);
        end
        else if (cfg_write)
        begin
            stream_length_reg <= pwdata[PB-1:0];
        end
    end

    // Decode step on the incoming word.
    gvwd_decode u_decode
    (
        .cur_state     (state_reg),
        .in_byte       (s_axis_tdata),
        .stream_length (stream_length_reg),
        .next_state    (dec_next),
        .bundle        (dec_bundle)
    );

    // Handshakes: the bundle register frees up in the cycle its last word leaves.
    assign elem_last     = ({1'b0, index_reg} + CB'(1)) == bundle_reg.count;
    assign out_accept    = m_axis_tvalid && m_axis_tready;
    assign drain         = out_accept && elem_last;
    assign s_axis_tready = !bundle_valid_reg || drain;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign state_next    = in_accept ? dec_next : state_reg;

    // Parser state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.byte_position      <= '0;
            state_reg.tail_count         <= '0;
            state_reg.control_byte       <= '0;
            state_reg.word_in_group      <= '0;
            state_reg.bytes_left_in_word <= '0;
            state_reg.parse_phase        <= gvwd_pkg::PHASE_HEADER;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Result bundle register and the index of the word being offered.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bundle_valid_reg <= 1'b0;
            index_reg        <= '0;
        end
        else if (in_accept && (dec_bundle.count != '0))
        begin
            bundle_valid_reg <= 1'b1;
            index_reg        <= '0;
        end
        else if (drain)
        begin
            bundle_valid_reg <= 1'b0;
            index_reg        <= '0;
        end
        else if (out_accept)
        begin
            index_reg <= index_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept && (dec_bundle.count != '0))
        begin
            bundle_reg <= dec_bundle;
        end
    end

    // Output word: the first carries the data byte, the rest are zero fill.
    assign m_axis_tvalid   = bundle_valid_reg;
    assign m_axis_tdata    = (index_reg == 2'd0) ? bundle_reg.first_byte : 8'd0;
    assign m_axis_tlast    = elem_last;
    assign m_axis_tuser[0] = elem_last && bundle_reg.stream_last;
    assign m_axis_tuser[1] = bundle_reg.format_error;

    // Checks on the bundle bookkeeping.
    `GVWD_ASSERT_IMPL(a_bundle_nonempty, clk, rst_n, bundle_valid_reg, bundle_reg.count != '0)
    `GVWD_ASSERT_IMPL(a_index_in_range, clk, rst_n, bundle_valid_reg, (({1'b0, index_reg}) < bundle_reg.count))
    `GVWD_ASSERT_IMPL(a_ready_when_empty, clk, rst_n, !bundle_valid_reg, s_axis_tready)
    `GVWD_ASSERT_NEXT(a_header_silent, clk, rst_n,
                      in_accept && (state_reg.byte_position < PB'(2)) && !bundle_valid_reg,
                      !bundle_valid_reg)

endmodule

### bench/testbench.sv
// Self-checking bench for group_varint_word_decoder_unit: a directed table of streams,
// then random well-formed, truncated, tail-heavy and noisy streams, checked word by word.
// Depends on gvwd_pkg and the decoder RTL.
module testbench;

    localparam int TOTAL_ITEMS    = 350;
    localparam int SETTLE_CYCLES  = 8;
    localparam int END_CYCLES     = 16;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DIRECTED_ROWS  = 42;

    localparam logic [gvwd_pkg::CFG_ADDR_BITS-1:0] LENGTH_ADDR =
        gvwd_pkg::CFG_ADDR_BITS'(4 * gvwd_pkg::REG_STREAM_LENGTH);

    // One decompressed output word as seen on the master side.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       stream_done;
        logic       format_error;
    } out_word_t;

    typedef enum logic [1:0] {ROW_BYTE, ROW_CFG, ROW_IDLE} row_kind_t;
    typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_ONE} check_t;

    typedef struct packed {
        row_kind_t  kind;
        logic [23:0] value;
        check_t     check;
        out_word_t  want;
    } row_t;

    localparam out_word_t NO_WORD = '0;

    // Directed streams: empty stream at reset length, tail too long, control byte last,
    // one full group with every code, overrun into tail, overrun at stream end,
    // and the largest length lowered mid-stream.
    localparam row_t DIRECTED [DIRECTED_ROWS] = '{
        '{ROW_BYTE, 24'h0000A5, CHK_NONE,  NO_WORD},
        '{ROW_BYTE, 24'h0000FF, CHK_NONE,  NO_WORD},
        '{ROW_CFG,  24'd3,      CHK_NONE,  NO_WORD},
        '{ROW_BYTE, 24'h000000, CHK_NONE,  NO_WORD},
        '{ROW_BYTE, 24'h0000FF, CHK_NONE,  NO_WORD},
        '{ROW_BYTE, 24'h00005A, CHK_ONE,   '{8'h5A, 1'b1, 1'b1, 1'b0}},
        '{ROW_BYTE, 24'h00007E, CHK_NONE,  NO_WORD},
        '{ROW_BYTE, 24'h000000, CHK_NONE,  NO_WORD},
        '{ROW_BYTE, 24'h0000E4, CHK_ONE,   '{8'h00, 1'b1, 1'b1, 1'b1}},
        '{ROW_CFG,  24'd13,     CHK_NONE,  NO_WORD},
        '{ROW_BYTE, 24'h000000, CHK_NONE,  NO_WORD},
        '{ROW_BYTE, 24'h000000, CHK_NONE,  NO_WORD},
        '{ROW_BYTE, 24'h0000E4, CHK_NONE,  NO_WORD},
        '{ROW_BYTE, 24'h0000FF, CHK_MODEL, NO_WORD},
        '{ROW_BYTE, 24'h000000, CHK_MODEL, NO_WORD},
        '{ROW_BYTE, 24'h000080, CHK_MODEL, NO_WORD},
        '{ROW_BYTE, 24'h000001, CHK_MODEL, NO_WORD},
        '{ROW_IDLE, 24'd0,      CHK_NONE,  NO_WORD},
        '{ROW_BYTE, 24'h00007F, CHK_MODEL, NO_WORD},
        '{ROW_BYTE, 24'h0000FE, CHK_MODEL, NO_WORD},
        '{ROW_BYTE, 24'h000055, CHK_MODEL, NO_WORD},
        '{ROW_BYTE, 24'h0000AA, CHK_MODEL, NO_WORD},
        '{ROW_BYTE, 24'h000012, CHK_MODEL, NO_WORD},
        '{ROW_BYTE, 24'h000034, CHK_MODEL, NO_WORD},
        '{ROW_CFG,  24'd5,      CHK_NONE,  NO_WORD},
        '{ROW_BYTE, 24'h000000, CHK_NONE,  NO_WORD},
        '{ROW_BYTE, 24'h000001, CHK_NONE,  NO_WORD},
        '{ROW_BYTE, 24'h0000FF, CHK_NONE,  NO_WORD},
        '{ROW_BYTE, 24'h000011, CHK_ONE,   '{8'h11, 1'b1, 1'b0, 1'b0}},
        '{ROW_BYTE, 24'h000033, CHK_ONE,   '{8'h33, 1'b1, 1'b1, 1'b1}},
        '{ROW_CFG,  24'd4,      CHK_NONE,  NO_WORD},
        '{ROW_BYTE, 24'h000000, CHK_NONE,  NO_WORD},
        '{ROW_BYTE, 24'h000000, CHK_NONE,  NO_WORD},
        '{ROW_BYTE, 24'h0000C0, CHK_NONE,  NO_WORD},
        '{ROW_BYTE, 24'h000077, CHK_ONE,   '{8'h77, 1'b1, 1'b1, 1'b1}},
        '{ROW_CFG,  24'hFFFFFF, CHK_NONE,  NO_WORD},
        '{ROW_BYTE, 24'h000000, CHK_NONE,  NO_WORD},
        '{ROW_BYTE, 24'h000000, CHK_NONE,  NO_WORD},
        '{ROW_BYTE, 24'h000000, CHK_NONE,  NO_WORD},
        '{ROW_BYTE, 24'h000001, CHK_MODEL, NO_WORD},
        '{ROW_CFG,  24'd4,      CHK_NONE,  NO_WORD},
        '{ROW_BYTE, 24'h000002, CHK_MODEL, NO_WORD}
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [gvwd_pkg::CFG_ADDR_BITS-1:0] paddr = '0;
    logic [gvwd_pkg::CFG_DATA_BITS-1:0] pwdata = '0;
    logic [gvwd_pkg::CFG_DATA_BITS-1:0] prdata;
    logic        pready;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;     // [7:0] in_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;          // [7:0] out_byte
    logic        m_axis_tlast;          // run_last
    logic [1:0]  m_axis_tuser;          // [0] stream_done, [1] format_error

    group_varint_word_decoder_unit u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Decoder shadow state and the words it still owes.
    logic [23:0]       shadow_length = 24'd2;
    logic [23:0]       shadow_pos = '0;
    logic [7:0]        shadow_tail = '0;
    logic [7:0]        shadow_ctrl = '0;
    logic [1:0]        shadow_word = '0;
    logic [2:0]        shadow_left = '0;
    gvwd_pkg::phase_t  shadow_phase = gvwd_pkg::PHASE_HEADER;
    out_word_t         byte_words[$];
    out_word_t         decoded_words_q[$];

    int fail_count = 0;
    int burst_left = 0;
    int sent_items = 0;
    int idle_cycles = 0;

    // Stored byte count of word w of a control byte, most significant pair first.
    function automatic logic [2:0] word_size(input logic [7:0] c, input logic [1:0] w);
        int sh;
        sh = 6 - 2 * int'(w);
        return {1'b0, 2'((c >> sh) & 8'h03)} + 3'd1;
    endfunction

    function automatic void emit_byte(input logic [7:0] v);
        byte_words.push_back('{v, 1'b0, 1'b0, 1'b0});
    endfunction

    // Advance the shadow decoder by one input byte; the words it causes land in byte_words.
    task automatic decode_byte(input logic [7:0] b);
        logic [24:0] len;
        logic [24:0] body_end;
        logic        last;
        logic        err;
        int          fill;
        int          n;
        byte_words.delete();
        err = 1'b0;
        len = {1'b0, shadow_length};
        if (len < 25'd2)
            len = 25'd2;
        last = ({1'b0, shadow_pos} >= len - 25'd1);

        if (shadow_pos == 24'd0)
            shadow_phase = gvwd_pkg::PHASE_HEADER;
        else if (shadow_pos == 24'd1)
        begin
            shadow_tail  = b;
            shadow_phase = gvwd_pkg::PHASE_CONTROL;
        end
        else
        begin
            body_end = ({17'd0, shadow_tail} + 25'd2 > len) ? 25'd2
                                                            : len - {17'd0, shadow_tail};
            if ({1'b0, shadow_pos} >= body_end)
            begin
                // Raw tail byte; an unfinished group is abandoned here.
                if (shadow_phase == gvwd_pkg::PHASE_DATA)
                    err = 1'b1;
                shadow_phase = gvwd_pkg::PHASE_TAIL;
                emit_byte(b);
            end
            else if (shadow_phase != gvwd_pkg::PHASE_DATA)
            begin
                shadow_ctrl  = b;
                shadow_word  = 2'd0;
                shadow_left  = word_size(b, 2'd0);
                shadow_phase = gvwd_pkg::PHASE_DATA;
                if (last)
                begin
                    err = 1'b1;
                    emit_byte(8'h00);
                end
            end
            else
            begin
                emit_byte(b);
                if (shadow_left > 3'd0)
                    shadow_left = shadow_left - 3'd1;
                if (shadow_left == 3'd0)
                begin
                    // Zero fill for the missing high bytes of the finished word.
                    fill = 4 - int'(word_size(shadow_ctrl, shadow_word));
                    for (int z = 0; z < fill; z++)
                        emit_byte(8'h00);
                    if (shadow_word == 2'd3)
                    begin
                        shadow_word  = 2'd0;
                        shadow_phase = gvwd_pkg::PHASE_CONTROL;
                    end
                    else
                    begin
                        shadow_word = shadow_word + 2'd1;
                        shadow_left = word_size(shadow_ctrl, shadow_word);
                    end
                end
                if (last && shadow_phase == gvwd_pkg::PHASE_DATA)
                    err = 1'b1;
            end
        end

        n = byte_words.size();
        for (int k = 0; k < n; k++)
            byte_words[k].format_error = err;
        if (n > 0)
        begin
            byte_words[n-1].run_last    = 1'b1;
            byte_words[n-1].stream_done = last;
        end

        if (last)
        begin
            shadow_pos   = '0;
            shadow_phase = gvwd_pkg::PHASE_HEADER;
            shadow_word  = 2'd0;
            shadow_left  = 3'd0;
        end
        else
            shadow_pos = shadow_pos + 24'd1;
    endtask

    // Send one compressed byte in the current burst and record what it should cause.
    task automatic push_byte(input logic [7:0] b, input check_t chk, input out_word_t want);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do
            @(posedge clk);
        while (!s_axis_tready);
        decode_byte(b);
        case (chk)
            CHK_MODEL: foreach (byte_words[k]) decoded_words_q.push_back(byte_words[k]);
            CHK_ONE:   decoded_words_q.push_back(want);
            default:   ;
        endcase
        sent_items++;
        burst_left--;
    endtask

    // Stop sending and wait until every owed word has come and the block has settled.
    task automatic drain_output();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (decoded_words_q.size() > 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write stream_length over the configuration port while the block is idle.
    task automatic write_length(input logic [23:0] length);
        drain_output();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= LENGTH_ADDR;
        pwdata  <= {8'h00, length};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        shadow_length = length;
    endtask

    // Receiver: its stall mode is drawn anew at random; output words are checked in order.
    int        rx_cycle = 0;
    int        rx_mode = 0;
    int        rx_hold = 0;
    out_word_t seen_word;

    always @(posedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (decoded_words_q.size() == 0)
                begin
                    $error("unexpected output word: out_byte %0h", m_axis_tdata);
                    fail_count++;
                end
                else
                begin
                    seen_word = decoded_words_q.pop_front();
                    if (m_axis_tdata !== seen_word.out_byte)
                    begin
                        $error("out_byte expected %0h actual %0h",
                               seen_word.out_byte, m_axis_tdata);
                        fail_count++;
                    end
                    if (m_axis_tlast !== seen_word.run_last)
                    begin
                        $error("run_last expected %0b actual %0b",
                               seen_word.run_last, m_axis_tlast);
                        fail_count++;
                    end
                    if (m_axis_tuser[0] !== seen_word.stream_done)
                    begin
                        $error("stream_done expected %0b actual %0b",
                               seen_word.stream_done, m_axis_tuser[0]);
                        fail_count++;
                    end
                    if (m_axis_tuser[1] !== seen_word.format_error)
                    begin
                        $error("format_error expected %0b actual %0b",
                               seen_word.format_error, m_axis_tuser[1]);
                        fail_count++;
                    end
                end
            end

            rx_cycle++;
            if (rx_cycle % 64 == 0)
                rx_mode = $urandom_range(0, 2);
            if (rx_hold > 0)
            begin
                rx_hold--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                case (rx_mode)
                    0: m_axis_tready <= 1'b1;
                    1: m_axis_tready <= 1'($urandom_range(0, 1));
                    default:
                    begin
                        if ($urandom_range(0, 7) == 0)
                        begin
                            rx_hold = $urandom_range(0, 7);
                            m_axis_tready <= 1'b0;
                        end
                        else
                            m_axis_tready <= 1'b1;
                    end
                endcase
            end
        end
    end

    // Watchdog: ends the run when nothing moves for too long.
    always @(posedge clk)
    begin
        if (!rst_n || psel || (s_axis_tvalid && s_axis_tready)
            || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAILED: results differ");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Stimulus: directed table, then random streams until enough bytes have been sent.
    initial
    begin
        logic [7:0]  stream_q[$];
        logic [7:0]  cb;
        logic [23:0] length;
        int          kind;
        int          tails;
        int          groups;
        int          nbytes;
        int          drop;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < DIRECTED_ROWS; r++)
        begin
            case (DIRECTED[r].kind)
                ROW_CFG:  write_length(DIRECTED[r].value);
                ROW_IDLE: drain_output();
                default:  push_byte(DIRECTED[r].value[7:0], DIRECTED[r].check,
                                    DIRECTED[r].want);
            endcase
        end

        while (sent_items < TOTAL_ITEMS)
        begin
            stream_q.delete();
            kind = $urandom_range(0, 9);
            if (kind < 8)
            begin
                // Well-formed stream with random content; kinds 6 and 7 lose their end.
                stream_q.push_back(8'($urandom_range(0, 255)));
                tails = $urandom_range(0, 5);
                stream_q.push_back(8'(tails));
                groups = $urandom_range(0, 3);
                for (int g = 0; g < groups; g++)
                begin
                    cb = 8'($urandom_range(0, 255));
                    stream_q.push_back(cb);
                    for (int w = 0; w < 4; w++)
                        for (int j = 0; j < int'(word_size(cb, 2'(w))); j++)
                            stream_q.push_back(8'($urandom_range(0, 255)));
                end
                for (int t = 0; t < tails; t++)
                    stream_q.push_back(8'($urandom_range(0, 255)));
                if (kind >= 6)
                begin
                    drop = $urandom_range(1, 3);
                    while (drop > 0 && stream_q.size() > 2)
                    begin
                        void'(stream_q.pop_back());
                        drop--;
                    end
                end
                length = 24'(stream_q.size());
            end
            else if (kind == 8)
            begin
                // Tail count larger than the stream: everything after the header is raw.
                length = 24'($urandom_range(2, 10));
                stream_q.push_back(8'($urandom_range(0, 255)));
                stream_q.push_back(8'($urandom_range(int'(length) - 1, 255)));
                for (int j = 2; j < int'(length); j++)
                    stream_q.push_back(8'($urandom_range(0, 255)));
            end
            else
            begin
                // Noise, sometimes two streams under one length.
                length = 24'($urandom_range(2, 30));
                nbytes = int'(length) * $urandom_range(1, 2);
                for (int j = 0; j < nbytes; j++)
                    stream_q.push_back(8'($urandom_range(0, 255)));
            end

            write_length(length);
            foreach (stream_q[i])
                push_byte(stream_q[i], CHK_MODEL, NO_WORD);
        end

        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (decoded_words_q.size() > 0)
            @(posedge clk);
        repeat (END_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
